### rtl/core/rs769_pkg.sv
`timescale 1ns / 1ps

package rs769_pkg;

    localparam int COEFF_W   = 10;
    localparam int IDX_W     = 10;
    localparam int WORD_W    = 48;
    localparam int BYTE_W    = 8;
    localparam int SMALL_W   = 39;
    localparam int DIG_CNT_W = 3;
    localparam int BIW_W     = 3;
    localparam int GC_W      = 8;

    // Modulus and the rejection bounds.
    localparam logic [COEFF_W-1:0] Q        = 10'd769;
    localparam logic [WORD_W-1:0]  Q5       = 48'd268925323054849;
    localparam logic [SMALL_W-1:0] Q4       = 39'd349707832321;
    localparam logic [GC_W-1:0]    GROUPS   = 8'd204;
    localparam logic [IDX_W-1:0]   LAST_IDX = 10'd1023;
    localparam logic [IDX_W-1:0]   TAIL_IDX = 10'd1020;

    // Digit counts of the two word kinds.
    localparam logic [DIG_CNT_W-1:0] BIG_DIGITS   = 3'd5;
    localparam logic [DIG_CNT_W-1:0] SMALL_DIGITS = 3'd4;

    // Byte positions that close a word.
    localparam logic [BIW_W-1:0] BIG_LAST_BYTE   = 3'd5;
    localparam logic [BIW_W-1:0] SMALL_LAST_BYTE = 3'd4;

    // Division of an 18-bit partial remainder by 769: the quotient is
    // (v * RECIP_M) >> RECIP_SHIFT, exact for every v below 769 * 256.
    localparam int                STEP_W      = COEFF_W + BYTE_W;
    localparam int                RECIP_W     = 19;
    localparam logic [RECIP_W-1:0] RECIP_M    = 19'd349071;
    localparam int                RECIP_SHIFT = 28;
    localparam int                PROD_W      = STEP_W + RECIP_W;

    typedef enum logic [1:0] {
        PH_BIG,
        PH_SKIP,
        PH_SMALL,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        SP_IDLE,
        SP_DIV,
        SP_EMIT
    } split_state_t;

    typedef struct packed {
        logic                 start;
        logic [WORD_W-1:0]    word;
        logic [DIG_CNT_W-1:0] count;
        logic [IDX_W-1:0]     first_idx;
    } split_req_t;

endpackage

### rtl/core/rs769_splitter.sv
`timescale 1ns / 1ps

module rs769_splitter
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rs769_pkg::split_req_t  req,
    output logic                   idle,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [9:0]             coeff,
    output logic [9:0]             coeff_index,
    output logic                   run_last,
    output logic                   poly_done
);

    import rs769_pkg::*;

    split_state_t         state_reg, state_next;
    logic [WORD_W-1:0]    x_reg, x_next;
    logic [COEFF_W-1:0]   rem_reg, rem_next;
    logic [2:0]           byte_cnt_reg, byte_cnt_next;
    logic [DIG_CNT_W-1:0] digit_cnt_reg, digit_cnt_next;
    logic [DIG_CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;

    logic                 out_valid_reg, out_valid_next;
    logic [COEFF_W-1:0]   coeff_reg, coeff_next;
    logic [IDX_W-1:0]     index_reg, index_next;
    logic                 run_last_reg, run_last_next;
    logic                 poly_done_reg, poly_done_next;

    logic [STEP_W-1:0]    step_val;
    logic [PROD_W-1:0]    step_prod;
    logic [BYTE_W-1:0]    step_q;
    logic [STEP_W-1:0]    step_qq;
    logic [STEP_W-1:0]    step_r;
    logic                 slot_free;
    logic                 last_digit;

    // One byte of long division by 769, most significant byte first.
    always_comb
    begin
        step_val  = {rem_reg, x_reg[WORD_W-1 -: BYTE_W]};
        step_prod = PROD_W'(step_val) * PROD_W'(RECIP_M);
        step_q    = step_prod[RECIP_SHIFT +: BYTE_W];
        step_qq   = (STEP_W'(step_q) << 9) + (STEP_W'(step_q) << 8) + STEP_W'(step_q);
        step_r    = step_val - step_qq;
    end

    assign slot_free  = !out_valid_reg || out_ready;
    assign last_digit = (digit_cnt_reg == (count_reg - 3'd1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SP_IDLE:
            begin
                if (req.start)
                begin
                    state_next = SP_DIV;
                end
            end
            SP_DIV:
            begin
                if (byte_cnt_reg == 3'd5)
                begin
                    state_next = SP_EMIT;
                end
            end
            SP_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = last_digit ? SP_IDLE : SP_DIV;
                end
            end
            default:
            begin
                state_next = SP_IDLE;
            end
        endcase
    end

    always_comb
    begin
        x_next         = x_reg;
        rem_next       = rem_reg;
        byte_cnt_next  = byte_cnt_reg;
        digit_cnt_next = digit_cnt_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        coeff_next     = coeff_reg;
        index_next     = index_reg;
        run_last_next  = run_last_reg;
        poly_done_next = poly_done_reg;
        unique case (state_reg)
            SP_IDLE:
            begin
                if (req.start)
                begin
                    x_next         = req.word;
                    rem_next       = '0;
                    byte_cnt_next  = '0;
                    digit_cnt_next = '0;
                    count_next     = req.count;
                    idx_next       = req.first_idx;
                end
            end
            SP_DIV:
            begin
                x_next        = {x_reg[WORD_W-BYTE_W-1:0], step_q};
                rem_next      = step_r[COEFF_W-1:0];
                byte_cnt_next = byte_cnt_reg + 3'd1;
            end
            SP_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    coeff_next     = rem_reg;
                    index_next     = idx_reg;
                    run_last_next  = last_digit;
                    poly_done_next = (idx_reg == LAST_IDX);
                    rem_next       = '0;
                    byte_cnt_next  = '0;
                    digit_cnt_next = digit_cnt_reg + 3'd1;
                    idx_next       = idx_reg + 10'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        rem_reg       <= rem_next;
        byte_cnt_reg  <= byte_cnt_next;
        digit_cnt_reg <= digit_cnt_next;
        count_reg     <= count_next;
        idx_reg       <= idx_next;
        coeff_reg     <= coeff_next;
        index_reg     <= index_next;
        run_last_reg  <= run_last_next;
        poly_done_reg <= poly_done_next;
    end

    assign idle        = (state_reg == SP_IDLE);
    assign out_valid   = out_valid_reg;
    assign coeff       = coeff_reg;
    assign coeff_index = index_reg;
    assign run_last    = run_last_reg;
    assign poly_done   = poly_done_reg;

`ifndef NO_ASSERTIONS
    // A new word is only handed over while the unit is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == SP_IDLE)
        else $error("split request while busy");

    // The running remainder of the long division stays a valid residue.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != SP_IDLE |-> rem_reg < Q)
        else $error("division remainder out of range");

    // The digit counter never passes the number of digits requested.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != SP_IDLE |-> digit_cnt_reg < count_reg)
        else $error("digit count overrun");

    // The final coefficient is always the last one of its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && poly_done_reg |-> run_last_reg)
        else $error("poly_done without run_last");

    // Leaving the emit state to idle only happens after the last digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SP_EMIT && state_next == SP_IDLE |=> out_valid_reg && run_last_reg)
        else $error("unit went idle before its last digit");
`endif

endmodule

### rtl/core/rejection_sample_base769.sv
`timescale 1ns / 1ps

// Uniform sampler modulo 769. The input channel (in_valid / in_ready) carries
// one stream byte per beat in xof_byte; start_req high on a beat restarts the
// block so that this byte is the first of a new polynomial's stream.
// The output channel (out_valid / out_ready) carries one coefficient per beat
// with its position, run_last on the last coefficient caused by one input
// beat, and poly_done on coefficient 1023.
// A byte that does not complete a kept word leaves the digit unit idle, so
// in_ready stays high. A byte that completes a kept word starts the shared
// digit unit, which divides by 769 one byte per cycle through a reciprocal
// multiply: each digit takes a division step for each byte of the word and
// then an emit step. in_ready returns once the last digit is in the output
// register, after five digits for a big word and four for the final small
// word.
// If the receiver stalls, the finished coefficient waits in the output
// register and the digit unit holds in its emit step until it is taken.
// After reset the block behaves as if a start had been seen; it takes no
// clearing pass. Bytes after the polynomial is complete are taken and
// dropped until the next start.
module rejection_sample_base769
#(
    parameter int BIG_BLOCK_BYTES = 1368
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] xof_byte,
    input  logic       start_req,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [9:0] coeff,
    output logic [9:0] coeff_index,
    output logic       run_last,
    output logic       poly_done
);

    import rs769_pkg::*;

    localparam int POS_W  = $clog2(BIG_BLOCK_BYTES);
    localparam int USABLE = (BIG_BLOCK_BYTES / 6) * 6;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BIG_BLOCK_BYTES - 1);
    localparam logic [POS_W:0]   USABLE_L = (POS_W + 1)'(USABLE);

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  block_pos_reg, block_pos_next;
    logic [WORD_W-1:0] word_acc_reg, word_acc_next;
    logic [BIW_W-1:0]  byte_in_word_reg, byte_in_word_next;
    logic [GC_W-1:0]   group_count_reg, group_count_next;

    // Values seen by the current beat, after a possible restart.
    phase_t            ph_eff;
    logic [POS_W-1:0]  pos_eff;
    logic [WORD_W-1:0] acc_eff;
    logic [BIW_W-1:0]  biw_eff;
    logic [GC_W-1:0]   gc_eff;

    logic              accept;
    logic [POS_W-1:0]  pos_inc;
    logic              in_window;
    logic [WORD_W-1:0] acc_ins;
    logic              big_done;
    logic              small_done;
    logic              big_keep;
    logic              small_keep;
    logic [GC_W-1:0]   gc_inc;
    logic              last_group;

    split_req_t        req;
    logic              unit_idle;

    assign accept   = in_valid && in_ready;
    assign in_ready = unit_idle;

    always_comb
    begin
        ph_eff  = start_req ? PH_BIG : phase_reg;
        pos_eff = start_req ? '0 : block_pos_reg;
        acc_eff = start_req ? '0 : word_acc_reg;
        biw_eff = start_req ? '0 : byte_in_word_reg;
        gc_eff  = start_req ? '0 : group_count_reg;
    end

    // Byte lanes of the gathered word are zero until written, so placing the
    // byte into its lane is the same as OR-ing it in.
    always_comb
    begin
        acc_ins = acc_eff;
        for (int i = 0; i < 6; i++)
        begin
            if (biw_eff == BIW_W'(i))
            begin
                acc_ins[i*BYTE_W +: BYTE_W] = xof_byte;
            end
        end
    end

    always_comb
    begin
        pos_inc    = (pos_eff == LAST_POS) ? '0 : pos_eff + POS_W'(1);
        in_window  = ({1'b0, pos_eff} < USABLE_L);
        big_done   = (biw_eff == BIG_LAST_BYTE);
        small_done = (biw_eff == SMALL_LAST_BYTE);
        big_keep   = (acc_ins < Q5);
        small_keep = (acc_ins[SMALL_W-1:0] < Q4);
        gc_inc     = gc_eff + 8'd1;
        last_group = in_window && big_done && big_keep && (gc_inc == GROUPS);
    end

    // Phase sequencing.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (ph_eff)
                PH_BIG:
                begin
                    if (last_group)
                    begin
                        phase_next = (pos_inc == '0) ? PH_SMALL : PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_BIG;
                    end
                end
                PH_SKIP:
                begin
                    phase_next = (pos_inc == '0) ? PH_SMALL : PH_SKIP;
                end
                PH_SMALL:
                begin
                    phase_next = (small_done && small_keep) ? PH_DONE : PH_SMALL;
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_BIG;
                end
            endcase
        end
    end

    // Word gathering, block position and hand-over to the digit unit.
    always_comb
    begin
        block_pos_next    = block_pos_reg;
        word_acc_next     = word_acc_reg;
        byte_in_word_next = byte_in_word_reg;
        group_count_next  = group_count_reg;
        req.start         = 1'b0;
        req.word          = acc_ins;
        req.count         = BIG_DIGITS;
        req.first_idx     = IDX_W'({gc_eff, 2'b00}) + IDX_W'(gc_eff);
        if (accept)
        begin
            block_pos_next    = pos_eff;
            word_acc_next     = acc_eff;
            byte_in_word_next = biw_eff;
            group_count_next  = gc_eff;
            unique case (ph_eff)
                PH_BIG:
                begin
                    block_pos_next = pos_inc;
                    if (in_window)
                    begin
                        if (big_done)
                        begin
                            word_acc_next     = '0;
                            byte_in_word_next = '0;
                            if (big_keep)
                            begin
                                req.start        = 1'b1;
                                group_count_next = gc_inc;
                            end
                        end
                        else
                        begin
                            word_acc_next     = acc_ins;
                            byte_in_word_next = biw_eff + 3'd1;
                        end
                    end
                end
                PH_SKIP:
                begin
                    block_pos_next = pos_inc;
                end
                PH_SMALL:
                begin
                    req.count     = SMALL_DIGITS;
                    req.first_idx = TAIL_IDX;
                    req.word      = {{(WORD_W-SMALL_W){1'b0}}, acc_ins[SMALL_W-1:0]};
                    if (small_done)
                    begin
                        word_acc_next     = '0;
                        byte_in_word_next = '0;
                        req.start         = small_keep;
                    end
                    else
                    begin
                        word_acc_next     = acc_ins;
                        byte_in_word_next = biw_eff + 3'd1;
                    end
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_BIG;
            block_pos_reg    <= '0;
            word_acc_reg     <= '0;
            byte_in_word_reg <= '0;
            group_count_reg  <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            block_pos_reg    <= block_pos_next;
            word_acc_reg     <= word_acc_next;
            byte_in_word_reg <= byte_in_word_next;
            group_count_reg  <= group_count_next;
        end
    end

    rs769_splitter u_splitter
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .idle        (unit_idle),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .coeff       (coeff),
        .coeff_index (coeff_index),
        .run_last    (run_last),
        .poly_done   (poly_done)
    );

endmodule

### tb/rejection_sample_base769_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the modulo-769 rejection sampler. Stream bytes go
// in one beat at a time; every coefficient beat that comes out is compared
// with the oldest coefficient that the bench's own sampler model predicted.
module rejection_sample_base769_tb;

    import rs769_pkg::*;

    localparam int          BLOCK_LEN    = 1368;
    localparam int          WORD_BYTES   = 6;
    localparam int          SMALL_BYTES  = 5;
    localparam int          KEPT_TARGET  = 204;
    localparam int          TAIL_FIRST   = 1020;
    localparam int          FINAL_INDEX  = 1023;
    localparam int          TAIL_WAIT    = 40;
    localparam int          PRINT_CAP    = 50;
    localparam longint      CYCLE_LIMIT  = 5000000;
    localparam logic [47:0] MODULUS      = 48'd769;
    localparam logic [47:0] BIG_BOUND    = 48'd268925323054849;
    localparam logic [47:0] SMALL_BOUND  = 48'd349707832321;
    localparam logic [47:0] SMALL_MASK   = 48'h007F_FFFF_FFFF;

    typedef struct {
        logic [9:0] coeff;
        logic [9:0] idx;
        logic       run_last;
        logic       poly_done;
    } coeff_beat_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] xof_byte    = 8'h00;
    logic       start_req   = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [9:0] coeff;
    logic [9:0] coeff_index;
    logic       run_last;
    logic       poly_done;

    // Model of the sampler: its state and the coefficients still owed.
    phase_t      stream_phase;
    int unsigned block_byte;
    logic [47:0] word_buf;
    int unsigned word_bytes;
    int unsigned kept_words;
    coeff_beat_t coeff_exp_q[$];

    // Idle controls and run statistics.
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;
    int unsigned mismatch_cnt = 0;
    int unsigned bytes_sent = 0;
    int unsigned restarts = 0;
    int unsigned beats_checked = 0;
    int unsigned polys_done = 0;
    longint      cycle_cnt = 0;

    rejection_sample_base769
    #(
        .BIG_BLOCK_BYTES(BLOCK_LEN)
    )
    i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .xof_byte   (xof_byte),
        .start_req  (start_req),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .coeff      (coeff),
        .coeff_index(coeff_index),
        .run_last   (run_last),
        .poly_done  (poly_done)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // The run is cut off here if the block ever stops moving.
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles, %0d coefficients still owed.",
                 cycle_cnt, coeff_exp_q.size());
        $display("rejection_sample_base769 verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $time, msg);
        else if (mismatch_cnt == PRINT_CAP)
            $display("[%0t] Further mismatches are counted but not printed.", $time);
        mismatch_cnt++;
    endtask

    // Stall lengths drawn from three ranges: mostly the shortest, now and then a long one.
    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 93)
            return $urandom_range(3, 6);
        return $urandom_range(15, 40);
    endfunction

    // Bytes lean toward all-zero and all-one so that the rejection bounds
    // and the masking of small words get hit often.
    function automatic logic [7:0] random_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'h00;
        else if (r < 20)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void reset_model();
        stream_phase = PH_BIG;
        block_byte   = 0;
        word_buf     = '0;
        word_bytes   = 0;
        kept_words   = 0;
    endfunction

    // Splits a kept word into base-769 digits, low digit first, and queues
    // one coefficient beat per digit.
    function automatic void queue_digits(input logic [47:0] word,
                                        input int unsigned count,
                                        input int unsigned first);
        logic [47:0]  rest;
        coeff_beat_t  beat;
        int unsigned  d;
        int unsigned  ix;
        rest = word;
        for (d = 0; d < count; d++)
        begin
            ix             = first + d;
            beat.coeff     = 10'(rest % MODULUS);
            beat.idx       = 10'(ix);
            beat.run_last  = (d + 1 == count);
            beat.poly_done = (ix == FINAL_INDEX);
            coeff_exp_q.push_back(beat);
            rest = rest / MODULUS;
        end
    endfunction

    // Advances the model by one accepted stream byte.
    function automatic void predict_byte(input logic [7:0] b, input logic st);
        int unsigned usable;
        logic [47:0] small_word;
        usable = (BLOCK_LEN / WORD_BYTES) * WORD_BYTES;
        if (st)
            reset_model();
        case (stream_phase)
            PH_BIG:
            begin
                // Bytes past the last whole word of a block are dropped.
                if (block_byte < usable)
                begin
                    word_buf = word_buf | ({40'd0, b} << (8 * word_bytes));
                    word_bytes++;
                    if (word_bytes >= WORD_BYTES)
                    begin
                        if (word_buf < BIG_BOUND)
                        begin
                            queue_digits(word_buf, 5, 5 * kept_words);
                            kept_words++;
                        end
                        word_buf   = '0;
                        word_bytes = 0;
                    end
                end
                block_byte++;
                if (block_byte >= BLOCK_LEN)
                    block_byte = 0;
                // After the last group the rest of the block is skipped,
                // unless the group ended right on the block boundary.
                if (kept_words >= KEPT_TARGET)
                begin
                    stream_phase = (block_byte == 0) ? PH_SMALL : PH_SKIP;
                    word_buf     = '0;
                    word_bytes   = 0;
                end
            end
            PH_SKIP:
            begin
                block_byte++;
                if (block_byte >= BLOCK_LEN)
                begin
                    block_byte   = 0;
                    stream_phase = PH_SMALL;
                end
            end
            PH_SMALL:
            begin
                word_buf = word_buf | ({40'd0, b} << (8 * word_bytes));
                word_bytes++;
                if (word_bytes >= SMALL_BYTES)
                begin
                    small_word = word_buf & SMALL_MASK;
                    if (small_word < SMALL_BOUND)
                    begin
                        queue_digits(small_word, 4, TAIL_FIRST);
                        stream_phase = PH_DONE;
                    end
                    word_buf   = '0;
                    word_bytes = 0;
                end
            end
            default:
            begin
                // A completed polynomial ignores bytes until the next start.
            end
        endcase
    endfunction

    // Sends one byte: an optional idle gap, then valid held until in_ready
    // is seen at a clock edge. in_ready is sampled at the falling edge, where
    // it already holds the value that the next rising edge acts on.
    task automatic send_byte(input logic [7:0] b, input logic st);
        int unsigned gap;
        logic        rdy;
        gap = 0;
        if (!tx_quiet && $urandom_range(0, 99) < 40)
            gap = pick_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        xof_byte  <= b;
        start_req <= st;
        do
        begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end
        while (!rdy);
        predict_byte(b, st);
        bytes_sent++;
        if (st)
            restarts++;
    endtask

    task automatic send_word(input logic [47:0] w, input int unsigned nbytes,
                             input logic st_first);
        int unsigned i;
        for (i = 0; i < nbytes; i++)
            send_byte(w[8*i +: 8], st_first && (i == 0));
    endtask

    // Drops valid and waits until nothing is owed.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (coeff_exp_q.size() != 0);
    endtask

    task automatic shuffle_idling();
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
    endtask

    // Small words until the polynomial completes, then a few bytes that the
    // block must take and drop.
    task automatic finish_poly();
        while (stream_phase != PH_DONE)
            send_byte(random_byte(), 1'b0);
        repeat ($urandom_range(2, 8))
            send_byte(random_byte(), 1'b0);
    endtask

    // Straight out of reset with no start flag, then the rejection bound
    // from both sides, all-ones bytes, and a restart in the middle of a word.
    task automatic test_directed();
        send_word(48'd0, WORD_BYTES, 1'b0);
        send_word(BIG_BOUND - 48'd1, WORD_BYTES, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_word(BIG_BOUND, WORD_BYTES, 1'b1);
        send_word(48'h00FF_FFFF_FFFF, WORD_BYTES, 1'b0);
    endtask

    // The last group closes exactly at the end of the first block: just
    // enough words are forced out of range so that the kept words fill the
    // block, and the small words start with the very next byte.
    task automatic test_aligned_block_end();
        int unsigned slots;
        int unsigned rejects_left;
        int unsigned s;
        logic [47:0] w;
        slots        = BLOCK_LEN / WORD_BYTES - 1;
        rejects_left = BLOCK_LEN / WORD_BYTES - KEPT_TARGET;
        shuffle_idling();
        for (s = 0; s < slots; s++)
        begin
            w[31:0]  = $urandom;
            w[39:32] = 8'($urandom_range(0, 255));
            // A top byte of 245 or more always lies above the bound, one of
            // 243 or less always below it.
            if ($urandom_range(1, slots - s) <= rejects_left)
            begin
                w[47:40] = 8'($urandom_range(245, 255));
                rejects_left--;
            end
            else
                w[47:40] = 8'($urandom_range(0, 243));
            send_word(w, WORD_BYTES, s == 0);
        end
        w[31:0]  = $urandom;
        w[39:32] = 8'($urandom_range(0, 255));
        w[47:40] = 8'($urandom_range(0, 243));
        send_word(w, WORD_BYTES, 1'b0);
        finish_poly();
    endtask

    // A whole polynomial from random bytes. Midway the sender holds off until
    // every owed coefficient has come out. With restart_in_tail the stream
    // is restarted while the block skips the tail of a block.
    task automatic test_random_poly(input bit restart_in_tail);
        int unsigned n;
        int unsigned drain_at;
        n        = 0;
        drain_at = $urandom_range(300, 900);
        send_byte(random_byte(), 1'b1);
        while (stream_phase == PH_BIG)
        begin
            if (n % 200 == 0)
                shuffle_idling();
            if (n == drain_at)
                wait_drained();
            send_byte(random_byte(), 1'b0);
            n++;
        end
        if (restart_in_tail)
        begin
            repeat ($urandom_range(1, 20))
                send_byte(random_byte(), 1'b0);
            send_byte(random_byte(), 1'b1);
        end
        else
            finish_poly();
    endtask

    // Random bytes with an occasional start flag at any point of a word.
    task automatic test_noise_mix(input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
                shuffle_idling();
            send_byte(random_byte(), $urandom_range(0, 59) == 0);
        end
    endtask

    // Receiver: ready most of the time, with short and occasional long
    // stalls, and stretches with none at all.
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (!rx_quiet && $urandom_range(0, 99) < 25)
            begin
                out_ready  <= 1'b0;
                stall_left = pick_len() - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Each coefficient beat is taken at the falling edge before the rising
    // edge that accepts it, so the outputs are stable when read.
    initial
    begin
        coeff_beat_t got;
        coeff_beat_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid === 1'b1 && out_ready)
            begin
                got.coeff     = coeff;
                got.idx       = coeff_index;
                got.run_last  = run_last;
                got.poly_done = poly_done;
                beats_checked++;
                if (coeff_exp_q.size() == 0)
                    report_mismatch($sformatf("unexpected coefficient %0d at index %0d",
                                              got.coeff, got.idx));
                else
                begin
                    want = coeff_exp_q.pop_front();
                    if (got.coeff !== want.coeff)
                        report_mismatch($sformatf("index %0d: coeff %0d, expected %0d",
                                                  want.idx, got.coeff, want.coeff));
                    if (got.idx !== want.idx)
                        report_mismatch($sformatf("coeff_index %0d, expected %0d",
                                                  got.idx, want.idx));
                    if (got.run_last !== want.run_last)
                        report_mismatch($sformatf("index %0d: run_last %b, expected %b",
                                                  want.idx, got.run_last, want.run_last));
                    if (got.poly_done !== want.poly_done)
                        report_mismatch($sformatf("index %0d: poly_done %b, expected %b",
                                                  want.idx, got.poly_done, want.poly_done));
                    if (want.poly_done)
                        polys_done++;
                end
            end
        end
    end

    initial
    begin
        reset_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_aligned_block_end();
        test_random_poly(1'b0);
        test_random_poly(1'b1);
        test_noise_mix(370);

        // Let the last coefficients drain, then give the digit unit time to
        // show anything it should not.
        wait_drained();
        repeat (TAIL_WAIT) @(posedge clk);
        if (coeff_exp_q.size() != 0)
            report_mismatch($sformatf("%0d coefficients never came out",
                                      coeff_exp_q.size()));

        $display("Sent %0d stream bytes with %0d restarts; checked %0d coefficient beats.",
                 bytes_sent, restarts, beats_checked);
        $display("Completed %0d polynomials, one with its last group on a block boundary.",
                 polys_done);
        if (mismatch_cnt == 0)
            $display("rejection_sample_base769 verification clean");
        else
            $display("rejection_sample_base769 verification failed");
        $finish;
    end

endmodule
